[rtl/string_to_unsigned_parser_defines.svh]
// Assertion macros shared by the string to unsigned parser RTL.
`ifndef STRING_TO_UNSIGNED_PARSER_DEFINES_SVH
`define STRING_TO_UNSIGNED_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while reset is asserted.
`define STUP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while reset is asserted.
`define STUP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/stup_pkg.sv]
// Package with the request types, character codes and digit decoding of the parser.
package stup_pkg;

	localparam int CHAR_W  = 8;
	localparam int BASE_W  = 6;
	localparam int ACC_W   = 64;
	localparam int COUNT_W = 16;
	localparam int DIG_W   = 5;

	localparam longint unsigned MAX_CHARS_DEF = 64'd65535;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
	} item_t;

	typedef struct packed {
		logic [ACC_W-1:0]   value;
		logic [COUNT_W-1:0] consumed_count;
	} result_t;

	typedef struct packed {
		logic             ok;
		logic [DIG_W-1:0] val;
	} digit_t;

	// Maps 0-9, a-f and A-F to their digit values; anything else is not a digit.
	function automatic digit_t digit_decode(input logic [CHAR_W-1:0] c);
		digit_t d;
		logic [CHAR_W-1:0] off;
		d = '0;
		off = '0;
		if (c inside {[CH_0:CH_9]}) begin
			off = c - CH_0;
			d.ok = 1'b1;
			d.val = off[DIG_W-1:0];
		end else if (c inside {[CH_LA:CH_LF]}) begin
			off = c - CH_LA + 8'd10;
			d.ok = 1'b1;
			d.val = off[DIG_W-1:0];
		end else if (c inside {[CH_UA:CH_UF]}) begin
			off = c - CH_UA + 8'd10;
			d.ok = 1'b1;
			d.val = off[DIG_W-1:0];
		end
		return d;
	endfunction

endpackage

[rtl/stup_core.sv]
// Parse state and per-character update logic of the string to unsigned parser.
`include "string_to_unsigned_parser_defines.svh"

module stup_core #(
	parameter longint unsigned MAX_CHARS = stup_pkg::MAX_CHARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  stup_pkg::item_t             item,
	input  logic [stup_pkg::BASE_W-1:0] number_base,
	output stup_pkg::result_t           result
);
	import stup_pkg::*;

	localparam int POS_W = $clog2(MAX_CHARS + 1);
	localparam int CNT_W = (POS_W > COUNT_W) ? POS_W : COUNT_W;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS);

	localparam logic [1:0] PZ_NONE   = 2'd0;
	localparam logic [1:0] PZ_ZERO   = 2'd1;
	localparam logic [1:0] PZ_ZERO_X = 2'd2;

	typedef enum logic [3:0] {
		PH_SPACE  = 4'b0001,
		PH_PREFIX = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] x);
		return (x < POS_MAX) ? x + 1'b1 : POS_MAX;
	endfunction

	phase_t              phase_q, n_phase;
	logic                neg_q, n_neg;
	logic [BASE_W-1:0]   ebase_q, n_ebase;
	logic [ACC_W-1:0]    acc_q, n_acc;
	logic [POS_W-1:0]    pos_q, n_pos;
	logic [POS_W-1:0]    stop_q, n_stop;
	logic [1:0]          pend_q, n_pend;

	logic [CHAR_W-1:0]   c;
	logic                last;
	logic [BASE_W-1:0]   eb;
	logic [BASE_W-1:0]   tb;
	logic [POS_W-1:0]    nxt;
	logic                do_prefix;
	logic                do_take;
	digit_t              dig;
	logic                is_dig;
	logic [ACC_W-1:0]    mac;
	logic [CNT_W-1:0]    cnt_wide;

	assign c    = item.char_code;
	assign last = item.last_char;
	assign dig  = digit_decode(c);

	always_comb begin
		eb = (pos_q == '0 && phase_q == PH_SPACE) ? number_base : ebase_q;
		nxt = sat_inc(pos_q);
		n_phase = phase_q;
		n_neg = neg_q;
		n_ebase = eb;
		n_acc = acc_q;
		n_pos = nxt;
		n_stop = stop_q;
		n_pend = pend_q;
		tb = eb;
		do_prefix = 1'b0;
		do_take = 1'b0;

		case (phase_q)
			PH_SPACE: begin
				if (c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
					n_stop = nxt;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					n_neg = (c == CH_MINUS);
					n_stop = nxt;
					n_phase = PH_PREFIX;
				end else begin
					n_phase = PH_PREFIX;
					do_prefix = 1'b1;
				end
			end
			PH_PREFIX: begin
				do_prefix = 1'b1;
			end
			PH_DIGITS: begin
				do_take = 1'b1;
			end
			default: begin
			end
		endcase

		if (do_prefix) begin
			case (pend_q)
				PZ_NONE: begin
					if ((eb == BASE_AUTO || eb == BASE_HEX) && c == CH_0 && !last) begin
						n_pend = PZ_ZERO;
					end else begin
						tb = (eb == BASE_AUTO) ? BASE_DEC : eb;
						n_phase = PH_DIGITS;
						do_take = 1'b1;
					end
				end
				PZ_ZERO: begin
					if ((c == CH_LX || c == CH_UX) && !last) begin
						n_pend = PZ_ZERO_X;
					end else begin
						// The zero stands as the octal prefix or as a plain digit.
						tb = (eb == BASE_AUTO) ? BASE_OCT : eb;
						n_pend = PZ_NONE;
						n_stop = sat_inc(stop_q);
						n_phase = PH_DIGITS;
						do_take = 1'b1;
					end
				end
				default: begin
					tb = BASE_HEX;
					n_pend = PZ_NONE;
					n_stop = sat_inc(sat_inc(stop_q));
					n_phase = PH_DIGITS;
					do_take = 1'b1;
				end
			endcase
			n_ebase = tb;
		end

		is_dig = dig.ok && ({1'b0, dig.val} < tb);
		mac = acc_q * ACC_W'(tb) + ACC_W'(dig.val);

		if (do_take) begin
			if (is_dig) begin
				n_acc = mac;
				n_stop = nxt;
			end else begin
				n_phase = PH_DONE;
			end
		end

		cnt_wide = CNT_W'(n_stop);
		result.value = n_neg ? (ACC_W'(0) - n_acc) : n_acc;
		result.consumed_count = cnt_wide[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q <= 1'b0;
			ebase_q <= '0;
			acc_q <= '0;
			pos_q <= '0;
			stop_q <= '0;
			pend_q <= PZ_NONE;
		end else if (step) begin
			if (last) begin
				phase_q <= PH_SPACE;
				neg_q <= 1'b0;
				ebase_q <= '0;
				acc_q <= '0;
				pos_q <= '0;
				stop_q <= '0;
				pend_q <= PZ_NONE;
			end else begin
				phase_q <= n_phase;
				neg_q <= n_neg;
				ebase_q <= n_ebase;
				acc_q <= n_acc;
				pos_q <= n_pos;
				stop_q <= n_stop;
				pend_q <= n_pend;
			end
		end
	end

	`STUP_ASSERT_IMP(a_pend_in_prefix, pend_q != PZ_NONE, phase_q == PH_PREFIX, "Prefix zero pending outside the prefix phase.")
	`STUP_ASSERT_IMP(a_pos_bounded, 1'b1, pos_q <= POS_MAX, "Position count beyond its saturation limit.")
	`STUP_ASSERT_IMP(a_stop_behind_pos, 1'b1, stop_q <= pos_q, "Stop position ahead of the position count.")

endmodule

[rtl/string_to_unsigned_parser.sv]
// Top level of the string to unsigned parser: request registers and configuration.
// The parser takes one character request per cycle and returns one result request on the
// character marked last: the number, negated modulo 2^64 after a minus sign, and the
// count of characters consumed. A character is registered on acceptance and then processed
// by the single multiply-add stage that updates the accumulator; a result passes through
// the input register and the result register before it is offered. The sustained rate is
// one character per cycle; only a result left waiting on the output holds up the input.
// The number base register is sampled on the first character of each string.
`include "string_to_unsigned_parser_defines.svh"

module string_to_unsigned_parser #(
	parameter longint unsigned MAX_CHARS = stup_pkg::MAX_CHARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  stup_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output stup_pkg::result_t           result,
	input  logic                        cfg_we,
	input  logic [stup_pkg::BASE_W-1:0] cfg_data
);
	import stup_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	logic              result_valid_q;
	result_t           result_q;
	logic [BASE_W-1:0] base_q;
	logic              out_free;
	logic              step;
	result_t           core_result;

	assign out_free     = !result_valid_q || result_ready;
	assign step         = valid_s1 && (!item_s1.last_char || out_free);
	assign item_ready   = !valid_s1 || step;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_AUTO;
		end else if (cfg_we) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	stup_core #(
		.MAX_CHARS(MAX_CHARS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(item_s1),
		.number_base(base_q),
		.result(core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step && item_s1.last_char) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.last_char) begin
			result_q <= core_result;
		end
	end

	`STUP_ASSERT_NXT(a_last_gives_result, step && item_s1.last_char, result_valid_q, "Last character processed without a result.")
	`STUP_ASSERT_IMP(a_stall_reason, !item_ready, valid_s1 && item_s1.last_char && result_valid_q && !result_ready, "Input stalled without a waiting result.")
	`STUP_ASSERT_NXT(a_accept_lands, item_valid && item_ready, valid_s1, "Accepted character missing from the input register.")

endmodule

[dv/string_to_unsigned_parser_test.sv]
// Self-checking testbench for the string to unsigned parser, with a built-in parse predictor.
module string_to_unsigned_parser_test;
	import stup_pkg::*;

	localparam int RESULT_LATENCY = 1;
	localparam int IDLE_LIMIT     = 2000;
	localparam int NUM_PHASES     = 12;
	localparam int PHASE_CHARS    = 108;

	typedef enum logic [1:0] {SCAN_SPACE, SCAN_PREFIX, SCAN_DIGITS, SCAN_DONE} scan_state_t;
	typedef enum logic [1:0] {ZERO_NONE, ZERO_SEEN, ZERO_X_SEEN} zero_state_t;
	typedef logic [CHAR_W-1:0] char_q_t [$];

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	item_t               item = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	result_t             result;
	logic                cfg_we = 1'b0;
	logic [BASE_W-1:0]   cfg_data = '0;

	item_t               pending_chars [$];
	result_t             expected_results [$];
	result_t             want;
	logic                calm = 1'b0;
	int                  send_gap = 0;
	int                  stall_left = 0;
	int                  idle_cycles = 0;
	int                  fail_count = 0;
	int                  results_checked = 0;
	int                  chars_seen = 0;
	int                  chars_queued = 0;
	int                  strings_queued = 0;
	int                  settings_used = 0;

	scan_state_t         scan_state;
	zero_state_t         zero_state;
	logic [BASE_W-1:0]   base_copy = BASE_AUTO;
	logic [BASE_W-1:0]   radix;
	logic                neg_seen;
	logic [ACC_W-1:0]    acc;
	longint unsigned     pos_cnt;
	longint unsigned     end_pos;

	string_to_unsigned_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint unsigned sat_inc(input longint unsigned x);
		return (x < MAX_CHARS_DEF) ? x + 1 : MAX_CHARS_DEF;
	endfunction

	function automatic int char_digit(input logic [CHAR_W-1:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
		if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	task automatic clear_parse();
		scan_state = SCAN_SPACE;
		zero_state = ZERO_NONE;
		neg_seen = 1'b0;
		radix = '0;
		acc = '0;
		pos_cnt = 0;
		end_pos = 0;
	endtask

	task automatic take_digit(input logic [CHAR_W-1:0] c, input longint unsigned nxt);
		int d;
		d = char_digit(c);
		if (d >= 0 && d < int'(radix)) begin
			acc = acc * ACC_W'(radix) + ACC_W'(d);
			end_pos = nxt;
		end else begin
			scan_state = SCAN_DONE;
		end
	endtask

	task automatic scan_prefix(input logic [CHAR_W-1:0] c, input logic last,
			input longint unsigned nxt);
		case (zero_state)
			ZERO_NONE: begin
				if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_0 && !last) begin
					zero_state = ZERO_SEEN;
				end else begin
					if (radix == BASE_AUTO) radix = BASE_DEC;
					scan_state = SCAN_DIGITS;
					take_digit(c, nxt);
				end
			end
			ZERO_SEEN: begin
				if ((c == CH_LX || c == CH_UX) && !last) begin
					zero_state = ZERO_X_SEEN;
				end else begin
					// The zero is taken as the octal prefix, or as a plain digit.
					if (radix == BASE_AUTO) radix = BASE_OCT;
					zero_state = ZERO_NONE;
					acc = '0;
					end_pos = sat_inc(end_pos);
					scan_state = SCAN_DIGITS;
					take_digit(c, nxt);
				end
			end
			default: begin
				radix = BASE_HEX;
				zero_state = ZERO_NONE;
				end_pos = sat_inc(sat_inc(end_pos));
				scan_state = SCAN_DIGITS;
				take_digit(c, nxt);
			end
		endcase
	endtask

	task automatic parse_char(input item_t it);
		logic [CHAR_W-1:0] c;
		logic last;
		longint unsigned nxt;
		result_t r;
		c = it.char_code;
		last = it.last_char;
		if (pos_cnt == 0 && scan_state == SCAN_SPACE) radix = base_copy;
		nxt = sat_inc(pos_cnt);
		case (scan_state)
			SCAN_SPACE: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					end_pos = nxt;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					neg_seen = (c == CH_MINUS);
					end_pos = nxt;
					scan_state = SCAN_PREFIX;
				end else begin
					scan_state = SCAN_PREFIX;
					scan_prefix(c, last, nxt);
				end
			end
			SCAN_PREFIX: scan_prefix(c, last, nxt);
			SCAN_DIGITS: take_digit(c, nxt);
			default: ;
		endcase
		pos_cnt = nxt;
		if (last) begin
			r.value = neg_seen ? ACC_W'(0) - acc : acc;
			r.consumed_count = COUNT_W'(end_pos);
			expected_results.push_back(r);
			clear_parse();
		end
	endtask

	function automatic logic [CHAR_W-1:0] digit_char(input int v);
		if (v < 10) return CH_0 + CHAR_W'(v);
		if ($urandom_range(0, 1) == 1) return CH_LA + CHAR_W'(v - 10);
		return CH_UA + CHAR_W'(v - 10);
	endfunction

	task automatic queue_string(input char_q_t s);
		item_t it;
		foreach (s[i]) begin
			it.char_code = s[i];
			it.last_char = (i == s.size() - 1);
			pending_chars.push_back(it);
		end
		chars_queued += s.size();
		strings_queued++;
	endtask

	task automatic queue_text(input string t);
		char_q_t s;
		for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
		queue_string(s);
	endtask

	// Mostly well-formed strings with random content; the rest are random bytes.
	task automatic gen_string(input logic [BASE_W-1:0] b);
		char_q_t s;
		int n;
		int lim;
		int style;
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) s.push_back(CHAR_W'($urandom_range(0, 255)));
		end else begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			repeat (n) begin
				if ($urandom_range(0, 5) == 5) s.push_back(CH_SPACE);
				else s.push_back(CH_TAB + CHAR_W'($urandom_range(0, 4)));
			end
			case ($urandom_range(0, 3))
				0: s.push_back(CH_MINUS);
				1: s.push_back(CH_PLUS);
				default: ;
			endcase
			lim = (b > BASE_HEX) ? 16 : int'(b);
			if (b == BASE_AUTO || b == BASE_HEX) begin
				style = $urandom_range(0, 3);
				if (style == 0) begin
					s.push_back(CH_0);
					s.push_back(($urandom_range(0, 1) == 1) ? CH_LX : CH_UX);
					lim = 16;
				end else if (style == 1 && b == BASE_AUTO) begin
					s.push_back(CH_0);
					lim = 8;
				end else if (b == BASE_AUTO) begin
					lim = 10;
				end
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 8);
			repeat (n) s.push_back(digit_char($urandom_range(0, lim - 1)));
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 2)) s.push_back(CHAR_W'($urandom_range(0, 255)));
			end
			if (s.size() == 0) s.push_back(CH_0);
		end
		queue_string(s);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_chars.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (RESULT_LATENCY + 2) @(negedge clk);
	endtask

	task automatic set_base(input logic [BASE_W-1:0] b);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_copy = b;
		settings_used++;
		@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_gap <= 0;
		end else if (!item_valid || item_ready) begin
			if (send_gap != 0) begin
				item_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_chars.size() != 0) begin
				item <= pending_chars.pop_front();
				item_valid <= 1'b1;
				send_gap <= calm ? 0 : pick_gap();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			result_ready <= 1'b1;
			stall_left <= calm ? 0 : pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				parse_char(item);
				chars_seen++;
			end
			if (result_valid && result_ready) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: value %h, consumed_count %0d",
						$time, result.value, result.consumed_count);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.value !== want.value) begin
						$display("%0t: value mismatch: expected %h, actual %h",
							$time, want.value, result.value);
						fail_count++;
					end
					if (result.consumed_count !== want.consumed_count) begin
						$display("%0t: consumed_count mismatch: expected %0d, actual %0d",
							$time, want.consumed_count, result.consumed_count);
						fail_count++;
					end
				end
			end
			if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("FAIL string_to_unsigned_parser");
		$finish;
	end

	initial begin
		logic [BASE_W-1:0] b;
		logic [BASE_W-1:0] phase_bases [NUM_PHASES];
		int mark;
		char_q_t run;
		phase_bases = '{BASE_AUTO, 6'd36, 6'd1, BASE_HEX, BASE_DEC, BASE_OCT,
			BASE_AUTO, 6'd2, 6'd0, BASE_AUTO, BASE_HEX, BASE_AUTO};
		clear_parse();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		set_base(BASE_AUTO);
		queue_text("0x1F");
		queue_text("017");
		queue_text("0");
		queue_text("0x");
		queue_text(" -12");
		queue_text("+0xg");
		queue_text("\t-");
		run = {8'hFF};
		queue_string(run);
		run = {8'h00, CH_0 + 8'd5};
		queue_string(run);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			b = (p == 8) ? BASE_W'($urandom_range(2, 35)) : phase_bases[p];
			set_base(b);
			calm = (p % 5 == 3);
			mark = chars_queued;
			while (chars_queued - mark < PHASE_CHARS) gen_string(b);
			wait_drained();
		end

		$display("Run covered %0d strings, %0d characters, over %0d base settings from 0 to 36;",
			strings_queued, chars_seen, settings_used);
		$display("%0d results checked, %0d mismatches.", results_checked, fail_count);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("PASS string_to_unsigned_parser");
		end else begin
			$display("FAIL string_to_unsigned_parser");
		end
		$finish;
	end

endmodule
